>>> rtl/dwc_pkg.sv
// dwc_pkg: shared constants, types and helpers of the depthwise 3x3 convolution block.
// Used by every module under rtl; depends on nothing.
`default_nettype none
package dwc_pkg;

	localparam int MAX_WIDTH   = 64;
	localparam int CHANNELS    = 3;
	localparam int KSIZE       = 3;
	localparam int SAMPLE_BITS = 8;

	localparam int TAPS        = KSIZE * KSIZE;
	localparam int NUM_WEIGHTS = CHANNELS * TAPS;
	localparam int TAP_BITS    = $clog2(TAPS);
	localparam int CH_BITS     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int WIDX_BITS   = 5;
	localparam int WEIGHT_BITS = 8;
	localparam int PIX_BITS    = CHANNELS * SAMPLE_BITS;
	localparam int COL_BITS    = $clog2(MAX_WIDTH);
	localparam int WREG_BITS   = 7;
	localparam int ROW_BITS    = 12;
	localparam int PROD_BITS   = WEIGHT_BITS + SAMPLE_BITS + 1;
	localparam int ROWSUM_BITS = PROD_BITS + 1;
	localparam int SUM_BITS    = 20;

	localparam int IN_BITS        = WIDX_BITS + WEIGHT_BITS + PIX_BITS;
	localparam int IN_TDATA_BITS  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS       = CHANNELS * SUM_BITS + COL_BITS + ROW_BITS;
	localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

	localparam int ADDR_BITS = 3;
	localparam logic [ADDR_BITS-1:0] REG_WIDTH_ADDR  = 3'd0;
	localparam logic [ADDR_BITS-1:0] REG_HEIGHT_ADDR = 3'd4;

	typedef enum logic {
		CMD_WEIGHT = 1'b0,
		CMD_PIXEL  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [COL_BITS-1:0] col;
		logic [ROW_BITS-1:0] row;
		logic                last;
	} meta_t;

	typedef struct packed {
		cmd_t                   cmd;
		logic [WIDX_BITS-1:0]   widx;
		logic [WEIGHT_BITS-1:0] wval;
		logic [PIX_BITS-1:0]    px;
		logic [PIX_BITS-1:0]    rda;
		logic [PIX_BITS-1:0]    rdb;
		logic [COL_BITS-1:0]    col;
		logic                   keep;
		meta_t                  meta;
	} s1_t;

	typedef struct packed {
		logic s1_go;
		logic ld_s2;
		logic ld_s3;
	} pipe_ctl_t;

	typedef struct packed {
		logic                upd;
		logic                wr;
		logic [TAP_BITS-1:0] tap;
		logic                ld_s2;
		logic                ld_s3;
	} lane_ctl_t;

	typedef struct packed {
		logic                ok;
		logic [CH_BITS-1:0]  ch;
		logic [TAP_BITS-1:0] tap;
	} wsel_t;

	function automatic wsel_t decode_widx(input logic [WIDX_BITS-1:0] idx);
		wsel_t r;
		r = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			if (idx >= WIDX_BITS'(c * TAPS) && idx < WIDX_BITS'((c + 1) * TAPS)) begin
				r.ok  = 1'b1;
				r.ch  = CH_BITS'(c);
				r.tap = TAP_BITS'(idx - WIDX_BITS'(c * TAPS));
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/dwc_front.sv
// dwc_front: input stage with row/column counters, the two line memories and the s1 register.
// Depends on dwc_pkg.
`default_nettype none
module dwc_front (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [dwc_pkg::IN_TDATA_BITS-1:0]    s_tdata,
	input  wire logic                                 s_tuser,
	input  wire logic [dwc_pkg::WREG_BITS-1:0]        width_q,
	input  wire logic [dwc_pkg::ROW_BITS-1:0]         height_q,
	input  wire logic                                 s1_go,
	output logic                                      v_s1,
	output dwc_pkg::s1_t                              s1
);

	logic [dwc_pkg::PIX_BITS-1:0] mem_a [dwc_pkg::MAX_WIDTH];
	logic [dwc_pkg::PIX_BITS-1:0] mem_b [dwc_pkg::MAX_WIDTH];

	logic [dwc_pkg::COL_BITS-1:0]  col_q;
	logic [dwc_pkg::ROW_BITS-1:0]  row_q;
	logic [dwc_pkg::WREG_BITS-1:0] w_eff;
	logic [dwc_pkg::ROW_BITS-1:0]  h_eff;
	logic [dwc_pkg::WREG_BITS-1:0] col_p1;
	logic [dwc_pkg::ROW_BITS:0]    row_p1;
	logic                          accept;
	logic                          acc_pix;
	dwc_pkg::cmd_t                 cmd;
	logic [dwc_pkg::PIX_BITS-1:0]  px;

	always_comb begin
		if (width_q < dwc_pkg::WREG_BITS'(3))
			w_eff = dwc_pkg::WREG_BITS'(3);
		else if (width_q > dwc_pkg::WREG_BITS'(dwc_pkg::MAX_WIDTH))
			w_eff = dwc_pkg::WREG_BITS'(dwc_pkg::MAX_WIDTH);
		else
			w_eff = width_q;
		h_eff = (height_q < dwc_pkg::ROW_BITS'(3)) ? dwc_pkg::ROW_BITS'(3) : height_q;
	end

	assign col_p1   = {1'b0, col_q} + dwc_pkg::WREG_BITS'(1);
	assign row_p1   = {1'b0, row_q} + (dwc_pkg::ROW_BITS + 1)'(1);
	assign s_tready = !v_s1 || s1_go;
	assign accept   = s_tvalid && s_tready;
	assign cmd      = dwc_pkg::cmd_t'(s_tuser);
	assign acc_pix  = accept && (cmd == dwc_pkg::CMD_PIXEL);
	assign px       = s_tdata[dwc_pkg::WIDX_BITS + dwc_pkg::WEIGHT_BITS +: dwc_pkg::PIX_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			if (accept)
				v_s1 <= 1'b1;
			else if (s1_go)
				v_s1 <= 1'b0;
			if (acc_pix) begin
				if (col_p1 >= w_eff) begin
					col_q <= '0;
					row_q <= (row_p1 >= {1'b0, h_eff}) ? '0 : row_p1[dwc_pkg::ROW_BITS-1:0];
				end else begin
					col_q <= col_p1[dwc_pkg::COL_BITS-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1.cmd       <= cmd;
			s1.widx      <= s_tdata[dwc_pkg::WIDX_BITS-1:0];
			s1.wval      <= s_tdata[dwc_pkg::WIDX_BITS +: dwc_pkg::WEIGHT_BITS];
			s1.px        <= px;
			s1.col       <= col_q;
			s1.keep      <= (row_q >= dwc_pkg::ROW_BITS'(2)) && (col_q >= dwc_pkg::COL_BITS'(2));
			s1.meta.col  <= col_q - dwc_pkg::COL_BITS'(2);
			s1.meta.row  <= row_q - dwc_pkg::ROW_BITS'(2);
			s1.meta.last <= (row_q == h_eff - dwc_pkg::ROW_BITS'(1))
				&& ({1'b0, col_q} == w_eff - dwc_pkg::WREG_BITS'(1));
		end
		// read both rows at the current column
		if (acc_pix) begin
			s1.rda <= mem_a[col_q];
			s1.rdb <= mem_b[col_q];
		end
	end

	// push the new pixel into the newer row
	always_ff @(posedge clk) begin
		if (acc_pix)
			mem_b[col_q] <= px;
		if (s1_go && v_s1 && s1.cmd == dwc_pkg::CMD_PIXEL)
			mem_a[s1.col] <= s1.rdb;
	end

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_pix && s1_go && v_s1 && s1.cmd == dwc_pkg::CMD_PIXEL) |-> (s1.col != col_q))
		else $error("line memory written and read at the same column");

	a_s1_load: assert property (@(posedge clk) disable iff (!arst_n)
		acc_pix |=> (v_s1 && s1.cmd == dwc_pkg::CMD_PIXEL && s1.col == $past(col_q)))
		else $error("accepted pixel did not reach s1");

endmodule
`default_nettype wire

>>> rtl/dwc_lane.sv
// dwc_lane: one channel lane: kernel weights, 3x3 window, nine products and row sums.
// Depends on dwc_pkg.
`default_nettype none
module dwc_lane (
	input  wire logic                                                  clk,
	input  wire logic                                                  arst_n,
	input  wire dwc_pkg::lane_ctl_t                                    ctl,
	input  wire logic [dwc_pkg::WEIGHT_BITS-1:0]                       wval,
	input  wire logic [dwc_pkg::KSIZE-1:0][dwc_pkg::SAMPLE_BITS-1:0]   cur,
	output logic [dwc_pkg::KSIZE-1:0][dwc_pkg::ROWSUM_BITS-1:0]        rowsum
);

	logic [dwc_pkg::WEIGHT_BITS-1:0]        w_q    [dwc_pkg::TAPS];
	logic [dwc_pkg::SAMPLE_BITS-1:0]        win_q  [2*dwc_pkg::KSIZE];
	logic signed [dwc_pkg::PROD_BITS-1:0]   prod_s2 [dwc_pkg::TAPS];
	logic signed [dwc_pkg::PROD_BITS-1:0]   prod   [dwc_pkg::TAPS];
	logic signed [dwc_pkg::SAMPLE_BITS:0]   samp   [dwc_pkg::TAPS];
	logic signed [dwc_pkg::ROWSUM_BITS-1:0] row_s3 [dwc_pkg::KSIZE];

	always_comb begin
		for (int ky = 0; ky < dwc_pkg::KSIZE; ky++) begin
			samp[ky*dwc_pkg::KSIZE]     = $signed({1'b0, win_q[ky]});
			samp[ky*dwc_pkg::KSIZE + 1] = $signed({1'b0, win_q[dwc_pkg::KSIZE + ky]});
			samp[ky*dwc_pkg::KSIZE + 2] = $signed({1'b0, cur[ky]});
		end
		for (int t = 0; t < dwc_pkg::TAPS; t++)
			prod[t] = dwc_pkg::PROD_BITS'($signed(w_q[t]) * samp[t]);
	end

	always_ff @(posedge clk) begin
		if (ctl.wr)
			w_q[ctl.tap] <= wval;
	end

	// shift the window one column left, new column from the line memories and the new pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 2*dwc_pkg::KSIZE; k++)
				win_q[k] <= '0;
		end else if (ctl.upd) begin
			for (int k = 0; k < dwc_pkg::KSIZE; k++) begin
				win_q[k]                 <= win_q[dwc_pkg::KSIZE + k];
				win_q[dwc_pkg::KSIZE + k] <= cur[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			for (int t = 0; t < dwc_pkg::TAPS; t++)
				prod_s2[t] <= prod[t];
		end
		if (ctl.ld_s3) begin
			for (int ky = 0; ky < dwc_pkg::KSIZE; ky++)
				row_s3[ky] <= dwc_pkg::ROWSUM_BITS'(prod_s2[ky*dwc_pkg::KSIZE])
					+ dwc_pkg::ROWSUM_BITS'(prod_s2[ky*dwc_pkg::KSIZE + 1])
					+ dwc_pkg::ROWSUM_BITS'(prod_s2[ky*dwc_pkg::KSIZE + 2]);
		end
	end

	always_comb begin
		for (int ky = 0; ky < dwc_pkg::KSIZE; ky++)
			rowsum[ky] = row_s3[ky];
	end

endmodule
`default_nettype wire

>>> rtl/dwc_merge.sv
// dwc_merge: pipeline control, coordinate pipeline and output register that adds the lane row sums.
// Depends on dwc_pkg.
`default_nettype none
module dwc_merge (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire logic                                         v_s1,
	input  wire logic                                         keep_s1,
	input  wire dwc_pkg::meta_t                               meta_s1,
	input  wire logic [dwc_pkg::CHANNELS-1:0][dwc_pkg::KSIZE-1:0][dwc_pkg::ROWSUM_BITS-1:0] rowsum,
	output dwc_pkg::pipe_ctl_t                                ctl,
	output logic                                              m_tvalid,
	input  wire logic                                         m_tready,
	output logic [dwc_pkg::OUT_TDATA_BITS-1:0]                m_tdata,
	output logic                                              m_tlast
);

	logic                          v_s2, v_s3;
	dwc_pkg::meta_t                meta_s2, meta_s3, meta_q;
	logic                          rdy_out, rdy_s3, rdy_s2;
	logic [dwc_pkg::SUM_BITS-1:0]  sum    [dwc_pkg::CHANNELS];
	logic [dwc_pkg::SUM_BITS-1:0]  sum_q  [dwc_pkg::CHANNELS];

	assign rdy_out   = !m_tvalid || m_tready;
	assign rdy_s3    = !v_s3 || rdy_out;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign ctl.s1_go = v_s1 && (!keep_s1 || rdy_s2);
	assign ctl.ld_s2 = ctl.s1_go && keep_s1;
	assign ctl.ld_s3 = v_s2 && rdy_s3;

	always_comb begin
		for (int c = 0; c < dwc_pkg::CHANNELS; c++) begin
			sum[c] = '0;
			for (int ky = 0; ky < dwc_pkg::KSIZE; ky++)
				sum[c] = sum[c] + dwc_pkg::SUM_BITS'($signed(rowsum[c][ky]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (ctl.ld_s2)
				v_s2 <= 1'b1;
			else if (ctl.ld_s3)
				v_s2 <= 1'b0;
			if (ctl.ld_s3)
				v_s3 <= 1'b1;
			else if (v_s3 && rdy_out)
				v_s3 <= 1'b0;
			if (v_s3 && rdy_out)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s2)
			meta_s2 <= meta_s1;
		if (ctl.ld_s3)
			meta_s3 <= meta_s2;
		if (v_s3 && rdy_out) begin
			meta_q <= meta_s3;
			for (int c = 0; c < dwc_pkg::CHANNELS; c++)
				sum_q[c] <= sum[c];
		end
	end

	always_comb begin
		m_tdata = '0;
		for (int c = 0; c < dwc_pkg::CHANNELS; c++)
			m_tdata[c*dwc_pkg::SUM_BITS +: dwc_pkg::SUM_BITS] = sum_q[c];
		m_tdata[dwc_pkg::CHANNELS*dwc_pkg::SUM_BITS +: dwc_pkg::COL_BITS] = meta_q.col;
		m_tdata[dwc_pkg::CHANNELS*dwc_pkg::SUM_BITS + dwc_pkg::COL_BITS +: dwc_pkg::ROW_BITS] =
			meta_q.row;
	end

	assign m_tlast = meta_q.last;

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !ctl.ld_s3) |-> !ctl.ld_s2)
		else $error("s2 overwritten while occupied");

	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && m_tvalid && !m_tready) |=> (v_s3 && $stable(meta_s3)))
		else $error("s3 lost while output stalled");

endmodule
`default_nettype wire

>>> rtl/depthwise_conv3x3_valid.sv
// Streaming valid-region 3x3 depthwise convolution over three channels, one pixel or weight
// request per clock while the output does not stall. The front stage reads both line memories
// at the current column, three channel lanes form the products and row sums, and the merge
// stage adds them into the output register. A result passes the s1, s2 and s3 registers and the
// output register after its pixel is accepted. Weights are applied in request order. Rows and
// columns below 2 give no result; tlast marks the last result of a frame.
`default_nettype none
module depthwise_conv3x3_valid (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// weight_index[4:0], weight_value[12:5], pixel_ch0[20:13], pixel_ch1[28:21], pixel_ch2[36:29]
	input  wire logic [dwc_pkg::IN_TDATA_BITS-1:0]   s_tdata,
	// command[0]
	input  wire logic                                s_tuser,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// sum_ch0[19:0], sum_ch1[39:20], sum_ch2[59:40], out_col[65:60], out_row[77:66]
	output logic [dwc_pkg::OUT_TDATA_BITS-1:0]       m_tdata,
	output logic                                     m_tlast,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [dwc_pkg::ADDR_BITS-1:0]       paddr,
	input  wire logic [31:0]                         pwdata,
	output logic [31:0]                              prdata,
	output logic                                     pready
);

	logic [dwc_pkg::WREG_BITS-1:0] width_q;
	logic [dwc_pkg::ROW_BITS-1:0]  height_q;
	logic                          v_s1;
	dwc_pkg::s1_t                  s1;
	dwc_pkg::pipe_ctl_t            pctl;
	dwc_pkg::wsel_t                wsel;
	logic [dwc_pkg::CHANNELS-1:0][dwc_pkg::KSIZE-1:0][dwc_pkg::ROWSUM_BITS-1:0] rowsum;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= dwc_pkg::WREG_BITS'(7);
			height_q <= dwc_pkg::ROW_BITS'(7);
		end else if (psel && penable && pwrite && pready) begin
			if (paddr == dwc_pkg::REG_WIDTH_ADDR)
				width_q <= pwdata[dwc_pkg::WREG_BITS-1:0];
			if (paddr == dwc_pkg::REG_HEIGHT_ADDR)
				height_q <= pwdata[dwc_pkg::ROW_BITS-1:0];
		end
	end

	always_comb begin
		unique case (paddr)
			dwc_pkg::REG_WIDTH_ADDR:  prdata = 32'(width_q);
			dwc_pkg::REG_HEIGHT_ADDR: prdata = 32'(height_q);
			default:                  prdata = '0;
		endcase
	end

	dwc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.width_q  (width_q),
		.height_q (height_q),
		.s1_go    (pctl.s1_go),
		.v_s1     (v_s1),
		.s1       (s1)
	);

	assign wsel = dwc_pkg::decode_widx(s1.widx);

	for (genvar c = 0; c < dwc_pkg::CHANNELS; c++) begin : g_lane
		dwc_pkg::lane_ctl_t                                  lctl;
		logic [dwc_pkg::KSIZE-1:0][dwc_pkg::SAMPLE_BITS-1:0] cur;

		assign lctl.upd   = pctl.s1_go && s1.cmd == dwc_pkg::CMD_PIXEL;
		assign lctl.wr    = pctl.s1_go && s1.cmd == dwc_pkg::CMD_WEIGHT && wsel.ok
			&& wsel.ch == dwc_pkg::CH_BITS'(c);
		assign lctl.tap   = wsel.tap;
		assign lctl.ld_s2 = pctl.ld_s2;
		assign lctl.ld_s3 = pctl.ld_s3;
		assign cur[0]     = s1.rda[c*dwc_pkg::SAMPLE_BITS +: dwc_pkg::SAMPLE_BITS];
		assign cur[1]     = s1.rdb[c*dwc_pkg::SAMPLE_BITS +: dwc_pkg::SAMPLE_BITS];
		assign cur[2]     = s1.px[c*dwc_pkg::SAMPLE_BITS +: dwc_pkg::SAMPLE_BITS];

		dwc_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (lctl),
			.wval   (s1.wval),
			.cur    (cur),
			.rowsum (rowsum[c])
		);
	end

	dwc_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_s1     (v_s1),
		.keep_s1  (s1.cmd == dwc_pkg::CMD_PIXEL && s1.keep),
		.meta_s1  (s1.meta),
		.rowsum   (rowsum),
		.ctl      (pctl),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire
